/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a signal group holds while a word stalls.
`define DTS_ASSERT_HOLD(lbl, clk, rst, stall, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    stall |=> $stable(sig)) else $error(msg);

`endif

/* rtl/dts_pkg.sv */
// Package: sizes, types and helpers of the depth-first topological sort.
package dts_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VTX_W        = $clog2(MAX_VERTICES + 1);
  localparam int CNT_W        = 7;
  localparam logic [CNT_W-1:0] RESET_COUNT = 7'd64;

  localparam int ADDR_W = 3;
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam int SCAN_BITS   = 8;
  localparam int SCAN_PW     = (SCAN_BITS > 1) ? $clog2(SCAN_BITS) : 1;
  localparam int SCAN_CHUNKS = (MAX_VERTICES + SCAN_BITS - 1) / SCAN_BITS;
  localparam int SCAN_CW     = (SCAN_CHUNKS > 1) ? $clog2(SCAN_CHUNKS) : 1;
  localparam int SCAN_PAD    = SCAN_CHUNKS * SCAN_BITS;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_ROOT,
    ST_ROOT_SCAN,
    ST_ADJ_WAIT,
    ST_NBR_SCAN,
    ST_POP_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] index;
  } scan_res_t;

  function automatic logic [MAX_VERTICES-1:0] count_mask(input logic [CNT_W-1:0] c);
    logic [MAX_VERTICES-1:0] m;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (i < int'(c));
    end
    return m;
  endfunction

endpackage

/* rtl/dfs_topological_sort.sv */
// Depth-first topological sort: each input word with has_edge set stores its
// directed edge, if both ends lie in 1..64, in a 64 x 64 adjacency RAM by a
// read-modify-write of one row through the RAM's read and write ports. The
// word marked last then holds off input while a depth-first search runs: each
// step reads one adjacency row and passes it through the shared find-first-set
// unit, which looks at 8 vertices per cycle; a pop adds one stack-RAM read, and
// the root search uses the same unit. Vertices leave in reverse finish order,
// order_last on the final one. After reset and after every run a clearing pass
// zeroes the adjacency RAM, during which in_ready stays low; vertex_count
// (register 0, reset 64) may be written over the APB port at any time the block
// is idle.
module dfs_topological_sort
  import dts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VTX_W-1:0]  edge_from,
  input  logic [VTX_W-1:0]  edge_to,
  input  logic              has_edge,
  input  logic              last_edge,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VTX_W-1:0]  order_vertex,
  output logic              order_last
);

  state_t state, state_next;

  logic [CNT_W-1:0]        vertex_count;
  logic [MAX_VERTICES-1:0] vmask;
  logic [MAX_VERTICES-1:0] visited;
  logic [IDX_W-1:0]        clr_idx;
  logic [IDX_W-1:0]        cur;
  logic [VTX_W-1:0]        depth;
  logic [VTX_W-1:0]        fc;
  logic [IDX_W-1:0]        ld_row;
  logic [IDX_W-1:0]        ld_to;
  logic                    ld_ok;
  logic                    ld_last;

  logic [VTX_W-1:0] from_m1, to_m1, depth_m1, depth_m2, fc_m1;
  logic             edge_ok;

  logic                    adj_we;
  logic [IDX_W-1:0]        adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    stk_we;
  logic [IDX_W-1:0]        stk_waddr, stk_raddr, stk_rdata;
  logic                    fin_we;
  logic [IDX_W-1:0]        fin_waddr, fin_raddr, fin_rdata;
  logic                    scan_start;
  logic [MAX_VERTICES-1:0] scan_word;
  scan_res_t               scan;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_VERTEX_COUNT) ? 32'(vertex_count) : '0;
  assign vmask  = count_mask(vertex_count);

  assign from_m1  = edge_from - VTX_W'(1);
  assign to_m1    = edge_to - VTX_W'(1);
  assign depth_m1 = depth - VTX_W'(1);
  assign depth_m2 = depth - VTX_W'(2);
  assign fc_m1    = fc - VTX_W'(1);
  assign edge_ok  = (edge_from != '0) && (edge_from <= VTX_W'(MAX_VERTICES)) &&
                    (edge_to != '0) && (edge_to <= VTX_W'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= RESET_COUNT;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[CNT_W-1:0];
    end
  end

  dts_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  dts_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(cur),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  dts_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_finish (
    .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(cur),
    .raddr(fin_raddr), .rdata(fin_rdata)
  );

  dts_scan u_scan (
    .clk(clk), .rst(rst), .start(scan_start), .word(scan_word), .res(scan)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr_idx == IDX_W'(MAX_VERTICES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (has_edge) begin
            state_next = ST_LOAD_WR;
          end else if (last_edge) begin
            state_next = ST_ROOT;
          end
        end
      end
      ST_LOAD_WR:   state_next = ld_last ? ST_ROOT : ST_IDLE;
      ST_ROOT:      state_next = ST_ROOT_SCAN;
      ST_ROOT_SCAN: begin
        if (scan.done) begin
          if (scan.found) begin
            state_next = ST_ADJ_WAIT;
          end else begin
            state_next = (fc != '0) ? ST_EMIT_RD : ST_CLEAR;
          end
        end
      end
      ST_ADJ_WAIT:  state_next = ST_NBR_SCAN;
      ST_NBR_SCAN: begin
        if (scan.done) begin
          if (scan.found) begin
            state_next = ST_ADJ_WAIT;
          end else begin
            state_next = (depth == VTX_W'(1)) ? ST_ROOT : ST_POP_WAIT;
          end
        end
      end
      ST_POP_WAIT:  state_next = ST_ADJ_WAIT;
      ST_EMIT_RD:   if (!out_valid) state_next = ST_EMIT_LD;
      ST_EMIT_LD:   state_next = (fc == '0) ? ST_CLEAR : ST_EMIT_RD;
      default:      state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    adj_we     = 1'b0;
    adj_waddr  = clr_idx;
    adj_wdata  = '0;
    adj_raddr  = from_m1[IDX_W-1:0];
    stk_we     = 1'b0;
    stk_waddr  = depth_m1[IDX_W-1:0];
    stk_raddr  = depth_m2[IDX_W-1:0];
    fin_we     = 1'b0;
    fin_waddr  = fc[IDX_W-1:0];
    fin_raddr  = fc_m1[IDX_W-1:0];
    scan_start = 1'b0;
    scan_word  = '0;
    case (state)
      ST_CLEAR:     adj_we = 1'b1;
      ST_IDLE:      in_ready = 1'b1;
      ST_LOAD_WR: begin
        adj_we    = ld_ok;
        adj_waddr = ld_row;
        adj_wdata = adj_rdata | (MAX_VERTICES'(1) << ld_to);
      end
      ST_ROOT: begin
        scan_start = 1'b1;
        scan_word  = ~visited & vmask;
      end
      ST_ROOT_SCAN: adj_raddr = scan.index;
      ST_ADJ_WAIT: begin
        scan_start = 1'b1;
        scan_word  = adj_rdata & ~visited & vmask;
      end
      ST_NBR_SCAN: begin
        adj_raddr = scan.index;
        if (scan.done) begin
          stk_we = scan.found;
          fin_we = !scan.found;
        end
      end
      ST_POP_WAIT:  adj_raddr = stk_rdata;
      ST_EMIT_RD,
      ST_EMIT_LD:   ;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      visited <= '0;
      depth   <= '0;
      fc      <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= (state == ST_CLEAR) ? clr_idx + 1'b1 : '0;
      case (state)
        ST_CLEAR: begin
          visited <= '0;
          depth   <= '0;
          fc      <= '0;
        end
        ST_ROOT_SCAN: begin
          if (scan.done && scan.found) begin
            visited[scan.index] <= 1'b1;
            cur   <= scan.index;
            depth <= VTX_W'(1);
          end
        end
        ST_NBR_SCAN: begin
          if (scan.done) begin
            if (scan.found) begin
              visited[scan.index] <= 1'b1;
              cur   <= scan.index;
              depth <= depth + 1'b1;
            end else begin
              fc    <= fc + 1'b1;
              depth <= depth_m1;
            end
          end
        end
        ST_POP_WAIT: cur <= stk_rdata;
        ST_EMIT_RD:  if (!out_valid) fc <= fc_m1;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      ld_row  <= from_m1[IDX_W-1:0];
      ld_to   <= to_m1[IDX_W-1:0];
      ld_ok   <= edge_ok;
      ld_last <= last_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT_LD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      order_vertex <= VTX_W'(fin_rdata) + VTX_W'(1);
      order_last   <= (fc == '0);
    end
  end

endmodule

/* rtl/dts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dts_scan.sv */
// Find-first-set unit: walks a vertex mask one byte per cycle.
module dts_scan
  import dts_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [MAX_VERTICES-1:0] word,
  output scan_res_t               res
);

  logic                busy;
  logic [SCAN_PAD-1:0] shreg;
  logic [SCAN_CW-1:0]  chunk;
  logic [SCAN_BITS-1:0] low;
  logic [SCAN_PW-1:0]  pos;
  logic                hit;
  logic                at_end;

  assign low    = shreg[SCAN_BITS-1:0];
  assign hit    = |low;
  assign at_end = (chunk == SCAN_CW'(SCAN_CHUNKS - 1));

  always_comb begin
    pos = '0;
    for (int i = SCAN_BITS - 1; i >= 0; i--) begin
      if (low[i]) begin
        pos = SCAN_PW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (hit || at_end)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= SCAN_PAD'(word);
      chunk <= '0;
    end else if (busy) begin
      shreg <= shreg >> SCAN_BITS;
      chunk <= chunk + 1'b1;
    end
  end

  always_comb begin
    res.done  = busy && (hit || at_end);
    res.found = busy && hit;
    res.index = IDX_W'({chunk, pos});
  end

endmodule

/* rtl/dts_checker.sv */
// Port-level checker for the topological sort, bound to the top level.
`include "assert_macros.svh"

module dts_checker
  import dts_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             has_edge,
  input logic             last_edge,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VTX_W-1:0] order_vertex,
  input logic             order_last
);

  logic in_fire, in_empty, in_work, out_stall, out_mid;

  assign in_fire   = in_valid && in_ready;
  assign in_empty  = in_fire && !has_edge && !last_edge;
  assign in_work   = in_fire && (has_edge || last_edge);
  assign out_stall = out_valid && !out_ready;
  assign out_mid   = out_valid && out_ready && !order_last;

  `DTS_ASSERT_HOLD(a_out_hold, clk, rst, out_stall, order_vertex, "stalled order word changed")
  `DTS_ASSERT(a_empty_word, clk, rst, in_empty |=> in_ready, "empty word dropped ready")
  `DTS_ASSERT(a_edge_rmw, clk, rst, in_work |=> !in_ready, "ready held after edge or last word")
  `DTS_ASSERT(a_emit_busy, clk, rst, out_mid |=> !in_ready, "input taken in the middle of an order")

endmodule

bind dfs_topological_sort dts_checker u_dts_checker (.*);
